@@ hw/rtl/dms_pkg.sv @@
package dms_pkg;

    localparam int TS_W         = 31;
    localparam int MK_W         = 32;
    localparam int WIN_W        = 16;
    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd10;

    typedef struct packed {
        logic load;
        logic pop;
        logic inc_idx;
        logic append;
        logic set_res;
        logic res_allow;
        logic res_ovf;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic expired;
        logic idx_end;
        logic full;
        logic match;
    } t_status;

endpackage

@@ hw/rtl/dms_ram.sv @@
module dms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dms_datapath.sv @@
module dms_datapath
    import dms_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [WIN_W-1:0] i_cfg_data,
    input  logic [TS_W-1:0]  i_timestamp,
    input  logic [MK_W-1:0]  i_message_key,
    input  t_cmd             i_cmd,
    output t_status          o_st,
    output logic             o_allow,
    output logic             o_overflow
);

    localparam int KW = (KEY_BITS < MK_W) ? KEY_BITS : MK_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [TS_W-1:0]  r_ts;
    logic [KW-1:0]    r_key;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_idx;
    logic [WIN_W-1:0] r_window;
    logic             r_res_allow;
    logic             r_res_ovf;
    logic             r_allow;
    logic             r_overflow;

    logic [CW:0]         w_rsum;
    logic [CW:0]         w_wsum;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic [KW+TS_W-1:0]  w_rdata;
    logic [KW-1:0]       w_rkey;
    logic [TS_W-1:0]     w_rtime;
    logic [TS_W-1:0]     w_age;

    // ring slot of head plus an offset
    always_comb begin
        w_rsum  = {{(CW + 1 - AW){1'b0}}, r_head} + {1'b0, r_idx};
        w_wsum  = {{(CW + 1 - AW){1'b0}}, r_head} + {1'b0, r_count};
        w_raddr = (w_rsum >= DEPTH_S) ? AW'(w_rsum - DEPTH_S) : AW'(w_rsum);
        w_waddr = (w_wsum >= DEPTH_S) ? AW'(w_wsum - DEPTH_S) : AW'(w_wsum);
    end

    dms_ram #(
        .WIDTH (KW + TS_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (w_waddr),
        .i_wdata ({r_key, r_ts}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rkey  = w_rdata[KW+TS_W-1:TS_W];
    assign w_rtime = w_rdata[TS_W-1:0];
    assign w_age   = r_ts - w_rtime;

    always_comb begin
        o_st.count_zero = (r_count == '0);
        o_st.expired    = (r_ts >= w_rtime)
                          ? (w_age >= {{(TS_W - WIN_W){1'b0}}, r_window})
                          : (r_window == '0);
        o_st.idx_end    = (r_idx == r_count);
        o_st.full       = (r_count == DEPTH_C);
        o_st.match      = (w_rkey == r_key);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_window <= WINDOW_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head  <= (r_head == LAST_A) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts  <= i_timestamp;
            r_key <= i_message_key[KW-1:0];
        end
        if (i_cmd.set_res) begin
            r_res_allow <= i_cmd.res_allow;
            r_res_ovf   <= i_cmd.res_ovf;
        end
        if (i_cmd.load_out) begin
            r_allow    <= r_res_allow;
            r_overflow <= r_res_ovf;
        end
    end

    assign o_allow    = r_allow;
    assign o_overflow = r_overflow;

endmodule

@@ hw/rtl/dms_ctrl.sv @@
module dms_ctrl
    import dms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RET_RD,
        S_RET_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RET_RD;
                end
            end
            S_RET_RD: begin
                n_state = i_st.count_zero ? S_SRCH_RD : S_RET_CHK;
            end
            S_RET_CHK: begin
                if (i_st.expired) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_RET_RD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_st.idx_end) begin
                    o_cmd.set_res = 1'b1;
                    if (i_st.full) begin
                        o_cmd.res_ovf = 1'b1;
                    end else begin
                        o_cmd.res_allow = 1'b1;
                        o_cmd.append    = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                if (i_st.match) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/duplicate_message_suppressor_core.sv @@
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_ready    i_timestamp, i_message_key
// out       output     o_out_valid / i_out_ready  o_allow, o_overflow
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (window)
//
// Each word is loaded, then the retire loop pops the oldest FIFO entry while it
// is expired, then the search loop compares the stored keys with the new key,
// and the retire and search loops each read one FIFO entry per read state and
// check state pair from the single-read-port store.
// Synchronous active-low reset empties the FIFO and sets the window to 10.
// A result held on a stalled output does not block the next input word;
// that word waits in its last step until the output register is free.
module duplicate_message_suppressor_core
    import dms_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [TS_W-1:0]  i_timestamp,
    input  logic [MK_W-1:0]  i_message_key,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_allow,
    output logic             o_overflow,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [WIN_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_st;

    assign o_cfg_ready = 1'b1;

    dms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_st        (w_st),
        .o_cmd       (w_cmd)
    );

    dms_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_timestamp   (i_timestamp),
        .i_message_key (i_message_key),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .o_allow       (o_allow),
        .o_overflow    (o_overflow)
    );

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_allow && o_overflow))
        else $error("allow and overflow both set");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready again straight after accept");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.append |-> !w_st.full)
        else $error("append into full FIFO");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !w_st.count_zero)
        else $error("retire from empty FIFO");

endmodule
